>>> sv/assert_macros.svh
// Concurrent assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> sv/tdsfp_pkg.sv
`timescale 1ns / 1ps

package tdsfp_pkg;

  typedef logic [3:0] count_t;

  localparam count_t SingleLen = 4'd6;
  localparam count_t DualLen   = 4'd12;
  localparam count_t CountMax  = 4'd15;

  // only bytes 1..10 carry payload words; the checksum bytes are compared on arrival
  localparam int BufFirst = 1;
  localparam int BufLast  = 10;

  // running sum ranges: bytes 0..4 for single frames, 6..10 for dual frames
  localparam count_t SumALast  = 4'd4;
  localparam count_t SumBFirst = 4'd6;
  localparam count_t SumBLast  = 4'd10;

  typedef enum logic [1:0] {
    ST_DUAL   = 2'd0,
    ST_SINGLE = 2'd1,
    ST_CSUM   = 2'd2,
    ST_LEN    = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] tds_pure;
    logic [15:0] raw_tds;
    logic [15:0] pure_temp_centi;
    logic [15:0] raw_temp_centi;
    logic        pure_changed;
    logic        raw_changed;
  } result_t;

endpackage

>>> sv/tdsfp_assembler.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module tdsfp_assembler
  import tdsfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [7:0]  rx_byte,
  input  logic        frame_end,
  output logic        push,
  output result_t     res
);

  logic [7:0]  buf_r [BufFirst:BufLast];
  count_t      cnt_r, cnt_nxt, cnt_inc;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [15:0] last_pure_r, last_pure_nxt;
  logic [15:0] last_raw_r, last_raw_nxt;
  logic [15:0] w_pure, w_raw, w_temp_a, w_temp_b;

  assign cnt_inc  = (cnt_r == CountMax) ? cnt_r : cnt_r + 4'd1;
  assign w_pure   = {buf_r[1], buf_r[2]};
  assign w_raw    = {buf_r[3], buf_r[4]};
  assign w_temp_a = {buf_r[7], buf_r[8]};
  assign w_temp_b = {buf_r[9], buf_r[10]};
  assign push     = acc && frame_end;

  always_comb begin
    res           = '0;
    res.status    = ST_LEN;
    last_pure_nxt = last_pure_r;
    last_raw_nxt  = last_raw_r;
    // the incoming byte is the checksum byte when the frame ends at a valid length
    if (cnt_inc == DualLen) begin
      if (sum_b_r == rx_byte) begin
        res.status          = ST_DUAL;
        res.tds_pure        = w_pure;
        res.raw_tds         = w_raw;
        res.pure_temp_centi = w_temp_a;
        res.raw_temp_centi  = w_temp_b;
        res.pure_changed    = (w_pure != last_pure_r);
        res.raw_changed     = (w_raw != last_raw_r);
        last_pure_nxt       = w_pure;
        last_raw_nxt        = w_raw;
      end else begin
        res.status = ST_CSUM;
      end
    end else if (cnt_inc == SingleLen) begin
      if (sum_a_r == rx_byte) begin
        res.status          = ST_SINGLE;
        res.tds_pure        = w_pure;
        res.pure_temp_centi = w_raw;
        res.pure_changed    = (w_pure != last_pure_r);
        last_pure_nxt       = w_pure;
      end else begin
        res.status = ST_CSUM;
      end
    end
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    if (acc) begin
      if (frame_end) begin
        cnt_nxt   = '0;
        sum_a_nxt = '0;
        sum_b_nxt = '0;
      end else begin
        cnt_nxt = cnt_inc;
        if (cnt_r <= SumALast) begin
          sum_a_nxt = sum_a_r + rx_byte;
        end
        if (cnt_r >= SumBFirst && cnt_r <= SumBLast) begin
          sum_b_nxt = sum_b_r + rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sum_a_r     <= '0;
      sum_b_r     <= '0;
      last_pure_r <= '0;
      last_raw_r  <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      if (push) begin
        last_pure_r <= last_pure_nxt;
        last_raw_r  <= last_raw_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && cnt_r >= count_t'(BufFirst) && cnt_r <= count_t'(BufLast)) begin
      buf_r[cnt_r] <= rx_byte;
    end
  end

  `ASSERT_CLK(a_cnt_clear, clk, rst_n, push |=> (cnt_r == '0 && sum_a_r == '0))
  `ASSERT_CLK(a_raw_dual_only, clk, rst_n,
              (push && res.status != ST_DUAL) |-> (!res.raw_changed && res.raw_tds == '0))
  `ASSERT_CLK(a_last_hold, clk, rst_n,
              (push && (res.status == ST_CSUM || res.status == ST_LEN)) |=>
              ($stable(last_pure_r) && $stable(last_raw_r)))

endmodule

>>> sv/tdsfp_out_q.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module tdsfp_out_q
  import tdsfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  result_t           ent_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PtrW:0]     cnt_r, cnt_nxt;
  logic              pop;

  assign space     = (cnt_r != (PtrW + 1)'(Depth));
  assign out_valid = (cnt_r != '0);
  assign out_data  = ent_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_NEVER(a_overflow, clk, rst_n, push && !space)
  `ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_r > (PtrW + 1)'(Depth))
  `ASSERT_CLK(a_ptr_track, clk, rst_n,
              (cnt_r == '0 || cnt_r == (PtrW + 1)'(Depth)) |-> (wr_ptr_r == rd_ptr_r))

endmodule

>>> sv/tds_sensor_frame_parser_top.sv
`timescale 1ns / 1ps

// Channel  | Dir | Handshake             | Payload
// in_      | in  | in_valid / in_ready   | rx_byte[7:0], frame_end
// out_     | out | out_valid / out_ready | status, tds, temps, change flags
//
// One byte per cycle while in_ready is high; a frame result is written into the result queue
// on its last byte and reaches out_ behind any results still queued. Frame state is a byte
// counter, two running checksums and the payload byte registers. Reset (rst_n low,
// synchronous) clears the counter, sums, last values and result queue. A two-entry result
// queue lets bytes keep flowing while out_ready is low; in_ready drops only when both entries hold untaken results.

module tds_sensor_frame_parser_top
  import tdsfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_tds_pure,
  output logic [15:0] out_raw_tds,
  output logic [15:0] out_pure_temp_centi,
  output logic [15:0] out_raw_temp_centi,
  output logic        out_pure_changed,
  output logic        out_raw_changed
);

  logic    acc;
  logic    push;
  result_t res;
  result_t out_data;

  assign acc = in_valid && in_ready;

  tdsfp_assembler u_asm (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .rx_byte   (in_rx_byte),
    .frame_end (in_frame_end),
    .push      (push),
    .res       (res)
  );

  tdsfp_out_q u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_status          = out_data.status;
  assign out_tds_pure        = out_data.tds_pure;
  assign out_raw_tds         = out_data.raw_tds;
  assign out_pure_temp_centi = out_data.pure_temp_centi;
  assign out_raw_temp_centi  = out_data.raw_temp_centi;
  assign out_pure_changed    = out_data.pure_changed;
  assign out_raw_changed     = out_data.raw_changed;

endmodule
